[design/cea_pkg.sv]
// Shared types and constants for the complex element-wise arithmetic unit.
`default_nettype none
package cea_pkg;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_MUL   = 3'd1,
		OP_DIV   = 3'd2,
		OP_CONJ  = 3'd3,
		OP_SQMAG = 3'd4,
		OP_SCALE = 3'd5,
		OP_RADD  = 3'd6
	} cea_op_t;

	localparam int QW = 33;
	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic        ovf;
		logic        dz;
		logic        dv;
	} cea_side_t;

	typedef struct packed {
		logic        neg;
		logic [63:0] mag;
	} cea_num_t;

	typedef struct packed {
		logic          neg;
		logic          sat;
		logic [QW-1:0] q;
	} cea_quo_t;

endpackage
`default_nettype wire

[design/cea_in_if.sv]
// Input channel: operation code and two complex operands.
`default_nettype none
interface cea_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         op;
	logic signed [31:0] a_re;
	logic signed [31:0] a_im;
	logic signed [31:0] b_re;
	logic signed [31:0] b_im;
	modport source(output valid, output op, output a_re, output a_im, output b_re,
		output b_im, input ready);
	modport sink(input valid, input op, input a_re, input a_im, input b_re,
		input b_im, output ready);
endinterface
`default_nettype wire

[design/cea_out_if.sv]
// Output channel: complex result and status flags.
`default_nettype none
interface cea_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] r_re;
	logic signed [31:0] r_im;
	logic               overflow;
	logic               divide_by_zero;
	modport source(output valid, output r_re, output r_im, output overflow,
		output divide_by_zero, input ready);
	modport sink(input valid, input r_re, input r_im, input overflow,
		input divide_by_zero, output ready);
endinterface
`default_nettype wire

[design/cea_div.sv]
// Pipelined two-lane restoring divider, one quotient bit per stage.
`default_nettype none
module cea_div import cea_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire cea_num_t [1:0]    num,
	input  wire logic [63:0]       den,
	input  wire cea_side_t         side_in,
	output logic                   out_valid,
	output cea_quo_t [1:0]         quo,
	output cea_side_t              side_out
);
	localparam int CW = (FRAC_BITS > QW) ? 64 + FRAC_BITS : 64 + QW;

	logic [QW:0]                   valid_s;
	logic [QW-1:0][1:0][CW-1:0]    rem_s;
	logic [QW-1:0][63:0]           den_s;
	cea_quo_t [QW:0][1:0]          quo_s;
	cea_side_t [QW:0]              side_s;

	logic [1:0][CW-1:0] rem0;
	logic [CW-1:0]      lim0;

	assign lim0 = CW'(den) << QW;
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rem0[l] = CW'(num[l].mag) << FRAC_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[QW-1:0], in_valid};
		end
	end

	// quotient at or above 2^33 saturates regardless of the low bits
	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= den;
			side_s[0] <= side_in;
			for (int l = 0; l < 2; l++) begin
				rem_s[0][l]     <= rem0[l];
				quo_s[0][l].neg <= num[l].neg;
				quo_s[0][l].sat <= rem0[l] >= lim0;
				quo_s[0][l].q   <= '0;
			end
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_stage
		localparam int K = QW - j;
		logic [CW-1:0] dsh;
		logic [1:0]    ge;

		assign dsh = CW'(den_s[j-1]) << K;
		always_comb begin
			for (int l = 0; l < 2; l++) begin
				ge[l] = rem_s[j-1][l] >= dsh;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j] <= side_s[j-1];
				for (int l = 0; l < 2; l++) begin
					quo_s[j][l].neg <= quo_s[j-1][l].neg;
					quo_s[j][l].sat <= quo_s[j-1][l].sat;
					quo_s[j][l].q   <= quo_s[j-1][l].q | (QW'(ge[l]) << K);
				end
			end
		end

		if (j < QW) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[j] <= den_s[j-1];
					for (int l = 0; l < 2; l++) begin
						rem_s[j][l] <= ge[l] ? rem_s[j-1][l] - dsh : rem_s[j-1][l];
					end
				end
			end
		end
	end

	assign out_valid = valid_s[QW];
	assign quo       = quo_s[QW];
	assign side_out  = side_s[QW];

endmodule
`default_nettype wire

[design/complex_elementwise_alu.sv]
// Complex element-wise arithmetic unit, signed fixed point, fully pipelined.
// Channels: req (sink) carries op, a_re, a_im, b_re, b_im; rsp (source) carries
// r_re, r_im, overflow, divide_by_zero. A transaction happens on valid & ready.
// Every operation takes the same path, so results leave in order.
// Pipeline: four front stages for operand capture, products, sums and rescale;
// 34 divider stages, the first setting up the dividend and saturation flag, the
// rest resolving one quotient bit each; one output register. Throughput: one
// transaction per cycle when not stalled; the whole pipeline advances together.
// Stall: when rsp holds a result that is not taken, the pipeline freezes and
// req.ready drops in the same cycle; nothing is lost or repeated.
// Reset: arst_n clears all stage valid bits; the first transaction can be
// accepted right after reset is released.
`default_nettype none
module complex_elementwise_alu import cea_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	cea_in_if.sink   req,
	cea_out_if.source rsp
);
	function automatic logic [32:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			return {1'b1, v[32] ? SAT_MIN : SAT_MAX};
		end
		return {1'b0, v[31:0]};
	endfunction

	function automatic logic [31:0] dz_part(input logic signed [31:0] v);
		if (v == '0) begin
			return '0;
		end
		return v[31] ? SAT_MIN : SAT_MAX;
	endfunction

	function automatic logic [32:0] quo_fin(input cea_quo_t z);
		if (z.neg) begin
			if (z.sat || z.q > {1'b0, SAT_MIN}) begin
				return {1'b1, SAT_MIN};
			end
			return {1'b0, 32'(-z.q[31:0])};
		end
		if (z.sat || z.q > {1'b0, SAT_MAX}) begin
			return {1'b1, SAT_MAX};
		end
		return {1'b0, z.q[31:0]};
	endfunction

	logic adv;
	assign adv = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	// stage 1: operands and results of the non-multiplying ops
	logic               valid_s1;
	cea_op_t            op_s1;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;
	cea_side_t          side_s1;
	cea_side_t          side_n1;

	always_comb begin
		logic [32:0] sr;
		logic [32:0] si;
		logic        dzero;
		side_n1 = '0;
		sr      = sat33(33'(req.a_re) + 33'(req.b_re));
		si      = sat33(33'(req.a_im) + 33'(req.b_im));
		dzero   = (req.b_re == '0) && (req.b_im == '0);
		case (cea_op_t'(req.op))
			OP_ADD: begin
				side_n1.re  = sr[31:0];
				side_n1.im  = si[31:0];
				side_n1.ovf = sr[32] | si[32];
			end
			OP_DIV: begin
				side_n1.dz = dzero;
				side_n1.dv = !dzero;
				side_n1.re = dz_part(req.a_re);
				side_n1.im = dz_part(req.a_im);
			end
			OP_CONJ: begin
				side_n1.re  = req.a_re;
				side_n1.im  = (req.a_im == SAT_MIN) ? SAT_MAX : 32'(-req.a_im);
				side_n1.ovf = req.a_im == SAT_MIN;
			end
			OP_RADD: begin
				side_n1.re  = sr[31:0];
				side_n1.im  = req.a_im;
				side_n1.ovf = sr[32];
			end
			default: begin
			end
		endcase
	end

	// stage 2: products
	logic               valid_s2;
	cea_op_t            op_s2;
	cea_side_t          side_s2;
	logic signed [63:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [31:0] x0, x1;

	assign x0 = (op_s1 == OP_SQMAG) ? ar_s1 : br_s1;
	assign x1 = (op_s1 == OP_SQMAG) ? ai_s1 : bi_s1;

	// stage 3: exact sums and divisor
	logic               valid_s3;
	cea_op_t            op_s3;
	cea_side_t          side_s3;
	logic signed [65:0] sre_s3, sim_s3;
	logic [63:0]        den_s3;
	logic signed [65:0] sre_n, sim_n;

	always_comb begin
		logic signed [65:0] e0, e1, e2, e3;
		e0 = 66'(m0_s2);
		e1 = 66'(m1_s2);
		e2 = 66'(m2_s2);
		e3 = 66'(m3_s2);
		case (op_s2)
			OP_MUL: begin
				sre_n = e0 - e1;
				sim_n = e3 + e2;
			end
			OP_DIV: begin
				sre_n = e0 + e1;
				sim_n = e3 - e2;
			end
			OP_SQMAG: begin
				sre_n = e0 + e1;
				sim_n = '0;
			end
			default: begin
				sre_n = e0;
				sim_n = e3;
			end
		endcase
	end

	// stage 4: rescale products, split dividend into sign and magnitude
	logic               valid_s4;
	cea_side_t          side_s4;
	cea_num_t [1:0]     num_s4;
	logic [63:0]        den_s4;
	cea_side_t          side_n4;
	cea_num_t [1:0]     num_n4;

	always_comb begin
		logic signed [65:0] shr [2];
		logic [1:0]         ov;
		logic [1:0][31:0]   pv;
		shr[0] = sre_s3 >>> FRAC_BITS;
		shr[1] = sim_s3 >>> FRAC_BITS;
		for (int l = 0; l < 2; l++) begin
			ov[l] = !((&shr[l][65:31]) || !(|shr[l][65:31]));
			pv[l] = ov[l] ? (shr[l][65] ? SAT_MIN : SAT_MAX) : shr[l][31:0];
		end
		side_n4 = side_s3;
		if (op_s3 == OP_MUL || op_s3 == OP_SQMAG || op_s3 == OP_SCALE) begin
			side_n4.re  = pv[0];
			side_n4.im  = pv[1];
			side_n4.ovf = |ov;
		end
		num_n4[0].neg = sre_s3[65];
		num_n4[0].mag = sre_s3[65] ? 64'(-sre_s3) : sre_s3[63:0];
		num_n4[1].neg = sim_s3[65];
		num_n4[1].mag = sim_s3[65] ? 64'(-sim_s3) : sim_s3[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= cea_op_t'(req.op);
			ar_s1   <= req.a_re;
			ai_s1   <= req.a_im;
			br_s1   <= req.b_re;
			bi_s1   <= req.b_im;
			side_s1 <= side_n1;

			op_s2   <= op_s1;
			side_s2 <= side_s1;
			m0_s2   <= ar_s1 * x0;
			m1_s2   <= ai_s1 * x1;
			m2_s2   <= ar_s1 * bi_s1;
			m3_s2   <= ai_s1 * br_s1;
			m4_s2   <= br_s1 * br_s1;
			m5_s2   <= bi_s1 * bi_s1;

			op_s3   <= op_s2;
			side_s3 <= side_s2;
			sre_s3  <= sre_n;
			sim_s3  <= sim_n;
			den_s3  <= 64'(m4_s2) + 64'(m5_s2);

			side_s4 <= side_n4;
			num_s4  <= num_n4;
			den_s4  <= den_s3;
		end
	end

	// divider
	logic           dv_valid;
	cea_quo_t [1:0] dv_quo;
	cea_side_t      dv_side;

	cea_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (valid_s4),
		.num      (num_s4),
		.den      (den_s4),
		.side_in  (side_s4),
		.out_valid(dv_valid),
		.quo      (dv_quo),
		.side_out (dv_side)
	);

	// output register
	logic        out_valid_q;
	logic [31:0] r_re_q, r_im_q;
	logic        ovf_q, dz_q;
	logic [32:0] fre, fim;

	assign fre = quo_fin(dv_quo[0]);
	assign fim = quo_fin(dv_quo[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dv_side.dv) begin
				r_re_q <= fre[31:0];
				r_im_q <= fim[31:0];
				ovf_q  <= fre[32] | fim[32];
				dz_q   <= 1'b0;
			end else begin
				r_re_q <= dv_side.re;
				r_im_q <= dv_side.im;
				ovf_q  <= dv_side.ovf;
				dz_q   <= dv_side.dz;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.r_re           = r_re_q;
	assign rsp.r_im           = r_im_q;
	assign rsp.overflow       = ovf_q;
	assign rsp.divide_by_zero = dz_q;

endmodule
`default_nettype wire

[dv/cea_checker.sv]
// Checker: watches both channels, predicts each result and compares in order.
`default_nettype none
module cea_checker import cea_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	cea_in_if.sink   req,
	cea_out_if.sink  rsp,
	output int       errors,
	output int       pending,
	output int       n_results
);

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic        ovf;
		logic        dz;
	} alu_result_t;

	alu_result_t result_q[$];

	function automatic logic [31:0] sat_signed(input logic signed [65:0] v, inout logic ovf);
		if (v > 66'sh7FFFFFFF) begin
			ovf = 1'b1;
			return SAT_MAX;
		end
		if (v < -66'sh80000000) begin
			ovf = 1'b1;
			return SAT_MIN;
		end
		return v[31:0];
	endfunction

	function automatic logic [31:0] rescale(input logic signed [65:0] s, inout logic ovf);
		logic signed [65:0] f;
		f = s >>> FRAC_BITS;
		return sat_signed(f, ovf);
	endfunction

	function automatic logic [31:0] divide_part(input logic signed [65:0] num,
		input logic [65:0] den, inout logic ovf);
		logic neg;
		logic [65:0] mag;
		logic [97:0] q;
		neg = num < 0;
		mag = neg ? -num : num;
		q = ({32'd0, mag} << FRAC_BITS) / {32'd0, den};
		if (neg) begin
			if (q > 98'h80000000) begin
				ovf = 1'b1;
				return SAT_MIN;
			end
			return -q[31:0];
		end
		if (q > 98'h7FFFFFFF) begin
			ovf = 1'b1;
			return SAT_MAX;
		end
		return q[31:0];
	endfunction

	function automatic logic [31:0] dz_part(input logic signed [31:0] a);
		if (a > 0) return SAT_MAX;
		if (a < 0) return SAT_MIN;
		return 32'd0;
	endfunction

	function automatic alu_result_t compute_result(input logic [2:0] op,
		input logic signed [31:0] ar, input logic signed [31:0] ai,
		input logic signed [31:0] br, input logic signed [31:0] bi);
		alu_result_t r;
		logic signed [65:0] xr, xi, yr, yi;
		logic [65:0] den;
		logic ovf;
		xr = ar;
		xi = ai;
		yr = br;
		yi = bi;
		ovf = 1'b0;
		r = '0;
		case (op)
			OP_ADD: begin
				r.re = sat_signed(xr + yr, ovf);
				r.im = sat_signed(xi + yi, ovf);
			end
			OP_MUL: begin
				r.re = rescale(xr * yr - xi * yi, ovf);
				r.im = rescale(xr * yi + xi * yr, ovf);
			end
			OP_DIV: begin
				den = yr * yr + yi * yi;
				if (den == 0) begin
					r.dz = 1'b1;
					r.re = dz_part(ar);
					r.im = dz_part(ai);
				end else begin
					r.re = divide_part(xr * yr + xi * yi, den, ovf);
					r.im = divide_part(xi * yr - xr * yi, den, ovf);
				end
			end
			OP_CONJ: begin
				r.re = ar;
				r.im = sat_signed(-xi, ovf);
			end
			OP_SQMAG: r.re = rescale(xr * xr + xi * xi, ovf);
			OP_SCALE: begin
				r.re = rescale(xr * yr, ovf);
				r.im = rescale(xi * yr, ovf);
			end
			OP_RADD: begin
				r.re = sat_signed(xr + yr, ovf);
				r.im = ai;
			end
			default: r = '0;
		endcase
		r.ovf = ovf;
		return r;
	endfunction

	assign pending = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		alu_result_t exp_r;
		alu_result_t got;
		if (!arst_n) begin
			errors <= 0;
			n_results <= 0;
			result_q.delete();
		end else begin
			if (req.valid && req.ready)
				result_q.push_back(compute_result(req.op, req.a_re, req.a_im,
					req.b_re, req.b_im));
			if (rsp.valid && rsp.ready) begin
				n_results <= n_results + 1;
				got = '{rsp.r_re, rsp.r_im, rsp.overflow, rsp.divide_by_zero};
				if (result_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result re=%h im=%h", got.re, got.im);
					errors <= errors + 1;
				end else begin
					exp_r = result_q.pop_front();
					if (got !== exp_r) begin
						if (errors < 10)
							$display("mismatch exp re=%h im=%h ovf=%b dz=%b got re=%h im=%h ovf=%b dz=%b",
								exp_r.re, exp_r.im, exp_r.ovf, exp_r.dz,
								got.re, got.im, got.ovf, got.dz);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

[dv/complex_elementwise_alu_tb.sv]
// Testbench top: stimulus, idling phases and verdict for the complex ALU.
`default_nettype none
module complex_elementwise_alu_tb import cea_pkg::*;;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   n_results;
	int   send_idle;
	int   recv_stall;
	int   n_sent;

	cea_in_if  req();
	cea_out_if rsp();

	complex_elementwise_alu dut(.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	cea_checker chk(.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.errors(errors), .pending(pending), .n_results(n_results));

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("complex_elementwise_alu_tb: errors");
		$finish;
	end

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_stall);
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'd0;
			3: return $urandom_range(2) << 16;
			4: return -($urandom_range(4) << 16);
			5, 6: return $urandom() >>> $urandom_range(31);
			default: return $urandom();
		endcase
	endfunction

	task automatic send(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
		input logic [31:0] br, input logic [31:0] bi);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.a_re <= ar;
		req.a_im <= ai;
		req.b_re <= br;
		req.b_im <= bi;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		n_sent++;
	endtask

	initial begin
		logic [31:0] m [4];
		m = '{32'h7FFFFFFF, 32'h80000000, 32'd0, 32'h00010000};
		req.valid = 1'b0;
		req.op = '0;
		req.a_re = '0;
		req.a_im = '0;
		req.b_re = '0;
		req.b_im = '0;
		rsp.ready = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		n_sent = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int op = 0; op < 8; op++)
			send(3'(op), m[2'(op)], m[2'(op + 1)], m[2'(op + 2)], m[2'(op + 3)]);
		send(OP_CONJ, 32'h5, 32'h80000000, 32'h0, 32'h0);
		send(OP_RADD, 32'h10000, 32'h1234, 32'h7FFFFFFF, 32'hFFFFFFFF);
		send(OP_DIV, 32'h10000, 32'hFFFF0000, 32'h0, 32'h0);
		send(OP_DIV, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0);
		send(OP_DIV, 32'h80000000, 32'h0, 32'h0, 32'h0);
		send(OP_DIV, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h0);
		send(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send(OP_SQMAG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
		send(OP_SCALE, 32'hFFFFFFFF, 32'h1, 32'h1, 32'h0);
		send(OP_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'hFFFFFFFF);
		for (int phase = 0; phase < 4; phase++) begin
			send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 69 : 38) : 0;
			recv_stall = (phase == 2 || phase == 3) ? (phase == 2 ? 69 : 38) : 0;
			for (int i = 0; i < 435; i++)
				send($urandom_range(20) == 0 ? 3'd7 : 3'($urandom_range(6)),
					pick_value(), pick_value(), pick_value(), pick_value());
		end
		req.valid <= 1'b0;
		recv_stall = 0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("sent %0d transactions over four idling phases, %0d results checked",
			n_sent, n_results);
		if (errors == 0 && pending == 0)
			$display("complex_elementwise_alu_tb: clean");
		else
			$display("complex_elementwise_alu_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
